@@ rtl/mbfps_pkg.sv @@
// ---------------------------------------------------------------------------
// mbfps_pkg
// Shared types and constants for the metaball field pixel shader.
// ---------------------------------------------------------------------------
`default_nettype none
package mbfps_pkg;

    localparam int NUM_SRC   = 3;
    localparam int X_W       = 9;
    localparam int Y_W       = 8;
    localparam int STR_W     = 16;
    localparam int D2_W      = 19;
    localparam int QSUM_W    = 18;
    localparam int INT_W     = 8;
    localparam int RGB_W     = 16;
    localparam int IDX_W     = 3;
    localparam int DIV_STEPS = STR_W;

    localparam logic [X_W-1:0]   RST_BALL_X   = X_W'(160);
    localparam logic [Y_W-1:0]   RST_BALL_Y   = Y_W'(120);
    localparam logic [STR_W-1:0] RST_STRENGTH = STR_W'(30000);
    localparam logic [INT_W-1:0] SAT_MAX      = INT_W'(255);

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_BALL0_X   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_BALL0_Y   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BALL1_X   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BALL1_Y   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_BALL2_X   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_BALL2_Y   = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_STRENGTH  = IDX_W'(6);

    typedef struct packed {
        logic [NUM_SRC-1:0][X_W-1:0] ball_x;
        logic [NUM_SRC-1:0][Y_W-1:0] ball_y;
        logic [STR_W-1:0]            strength;
    } t_cfg;

    typedef logic [NUM_SRC-1:0][D2_W-1:0]  t_d2_vec;
    typedef logic [NUM_SRC-1:0][STR_W-1:0] t_quo_vec;

endpackage
`default_nettype wire

@@ rtl/mbfps_if.sv @@
// ---------------------------------------------------------------------------
// mbfps interfaces
// Pixel request, shaded result and configuration write channels.
// ---------------------------------------------------------------------------
`default_nettype none
interface mbfps_pix_if;
    logic                     valid;
    logic                     ready;
    logic [mbfps_pkg::X_W-1:0] pixel_x;
    logic [mbfps_pkg::Y_W-1:0] pixel_y;
    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mbfps_shade_if;
    logic                       valid;
    logic                       ready;
    logic [mbfps_pkg::INT_W-1:0] intensity;
    logic [mbfps_pkg::RGB_W-1:0] color_rgb565;
    modport source (output valid, intensity, color_rgb565, input ready);
    modport sink   (input valid, intensity, color_rgb565, output ready);
endinterface

interface mbfps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mbfps_pkg::IDX_W-1:0] index;
    logic [mbfps_pkg::STR_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/metaball_field_pixel_shader_top.sv @@
// ---------------------------------------------------------------------------
// metaball_field_pixel_shader_top
// Inverse-square field of three sources per pixel, heat palette, RGB565.
//
//   channel   dir  payload                     role
//   i_pix     in   pixel_x, pixel_y            pixel request
//   o_shade   out  intensity, color_rgb565     shaded pixel
//   i_cfg     in   index, data                 register write
//
// one request per clock sustained while the output is not stalled; twenty
// register stages from accept to valid: two distance, sixteen divider, two shade.
// synchronous reset clears valids and loads default registers. a stall at
// the output freezes the whole pipeline in place.
// ---------------------------------------------------------------------------
`default_nettype none
module metaball_field_pixel_shader_top
    import mbfps_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    mbfps_pix_if.sink        i_pix,
    mbfps_shade_if.source    o_shade,
    mbfps_cfg_if.sink        i_cfg
);

    t_cfg     cfg;
    logic     en;
    logic     dist_valid;
    t_d2_vec  d2;
    logic     div_valid;
    t_quo_vec quo;

    assign en          = !o_shade.valid || o_shade.ready;
    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;

    mbfps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    mbfps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_px    (i_pix.pixel_x),
        .i_py    (i_pix.pixel_y),
        .i_cfg   (cfg),
        .o_valid (dist_valid),
        .o_d2    (d2)
    );

    mbfps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dist_valid),
        .i_num   (cfg.strength),
        .i_den   (d2),
        .o_valid (div_valid),
        .o_quo   (quo)
    );

    mbfps_shade u_shade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (div_valid),
        .i_quo       (quo),
        .o_valid     (o_shade.valid),
        .o_intensity (o_shade.intensity),
        .o_color     (o_shade.color_rgb565)
    );

endmodule
`default_nettype wire

@@ rtl/mbfps_cfg.sv @@
// ---------------------------------------------------------------------------
// mbfps_cfg
// Ball centre and field strength registers.
// ---------------------------------------------------------------------------
`default_nettype none
module mbfps_cfg
    import mbfps_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_we,
    input  wire [IDX_W-1:0]    i_index,
    input  wire [STR_W-1:0]    i_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                REG_BALL0_X:  n_cfg.ball_x[0] = i_data[X_W-1:0];
                REG_BALL0_Y:  n_cfg.ball_y[0] = i_data[Y_W-1:0];
                REG_BALL1_X:  n_cfg.ball_x[1] = i_data[X_W-1:0];
                REG_BALL1_Y:  n_cfg.ball_y[1] = i_data[Y_W-1:0];
                REG_BALL2_X:  n_cfg.ball_x[2] = i_data[X_W-1:0];
                REG_BALL2_Y:  n_cfg.ball_y[2] = i_data[Y_W-1:0];
                REG_STRENGTH: n_cfg.strength  = i_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SRC; k++) begin
                r_cfg.ball_x[k] <= RST_BALL_X;
                r_cfg.ball_y[k] <= RST_BALL_Y;
            end
            r_cfg.strength <= RST_STRENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ rtl/mbfps_dist.sv @@
// ---------------------------------------------------------------------------
// mbfps_dist
// Two stages: absolute offsets, then clamped squared distance per source.
// ---------------------------------------------------------------------------
`default_nettype none
module mbfps_dist
    import mbfps_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  wire [X_W-1:0]      i_px,
    input  wire [Y_W-1:0]      i_py,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output t_d2_vec            o_d2
);

    logic [1:0]                  r_valid;
    logic [NUM_SRC-1:0][X_W-1:0] r_dx;
    logic [NUM_SRC-1:0][Y_W-1:0] r_dy;
    t_d2_vec                     r_d2;
    logic [NUM_SRC-1:0][X_W-1:0] n_dx;
    logic [NUM_SRC-1:0][Y_W-1:0] n_dy;
    t_d2_vec                     n_d2;

    always_comb begin
        for (int k = 0; k < NUM_SRC; k++) begin
            n_dx[k] = (i_px >= i_cfg.ball_x[k]) ? i_px - i_cfg.ball_x[k]
                                                : i_cfg.ball_x[k] - i_px;
            n_dy[k] = (i_py >= i_cfg.ball_y[k]) ? i_py - i_cfg.ball_y[k]
                                                : i_cfg.ball_y[k] - i_py;
            n_d2[k] = D2_W'(r_dx[k] * r_dx[k]) + D2_W'(r_dy[k] * r_dy[k]);
            // pixel on a centre counts as distance one
            if (n_d2[k] == '0) begin
                n_d2[k] = D2_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_d2 <= n_d2;
        end
    end

    assign o_valid = r_valid[1];
    assign o_d2    = r_d2;

endmodule
`default_nettype wire

@@ rtl/mbfps_div.sv @@
// ---------------------------------------------------------------------------
// mbfps_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ---------------------------------------------------------------------------
`default_nettype none
module mbfps_div
    import mbfps_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  wire [STR_W-1:0]    i_num,
    input  t_d2_vec            i_den,
    output logic               o_valid,
    output t_quo_vec           o_quo
);

    logic [DIV_STEPS-1:0]                    r_valid;
    logic [DIV_STEPS-1:0][STR_W-1:0]         r_num;
    t_d2_vec                                 r_den [DIV_STEPS];
    t_d2_vec                                 r_rem [DIV_STEPS];
    t_quo_vec                                r_quo [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_STEPS-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [STR_W-1:0] st_num;
        t_d2_vec          st_den;
        t_d2_vec          st_rem;
        t_quo_vec         st_quo;
        t_d2_vec          n_rem;
        t_quo_vec         n_quo;

        if (s == 0) begin : g_first
            assign st_num = i_num;
            assign st_den = i_den;
            assign st_rem = '0;
            assign st_quo = '0;
        end else begin : g_next
            assign st_num = r_num[s-1];
            assign st_den = r_den[s-1];
            assign st_rem = r_rem[s-1];
            assign st_quo = r_quo[s-1];
        end

        always_comb begin
            logic [D2_W:0] trial;
            for (int k = 0; k < NUM_SRC; k++) begin
                trial = {st_rem[k], st_num[STR_W-1]};
                if (trial >= {1'b0, st_den[k]}) begin
                    n_rem[k] = D2_W'(trial - {1'b0, st_den[k]});
                    n_quo[k] = {st_quo[k][STR_W-2:0], 1'b1};
                end else begin
                    n_rem[k] = trial[D2_W-1:0];
                    n_quo[k] = {st_quo[k][STR_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= {st_num[STR_W-2:0], 1'b0};
                r_den[s] <= st_den;
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/mbfps_shade.sv @@
// ---------------------------------------------------------------------------
// mbfps_shade
// Sums the contributions with saturation, then maps through the heat palette.
// ---------------------------------------------------------------------------
`default_nettype none
module mbfps_shade
    import mbfps_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  t_quo_vec           i_quo,
    output logic               o_valid,
    output logic [INT_W-1:0]   o_intensity,
    output logic [RGB_W-1:0]   o_color
);

    logic [1:0]        r_valid;
    logic [INT_W-1:0]  r_int;
    logic [INT_W-1:0]  r_out_int;
    logic [RGB_W-1:0]  r_color;
    logic [QSUM_W-1:0] sum;
    logic [INT_W-1:0]  n_int;
    logic [7:0]        red;
    logic [7:0]        grn;
    logic [7:0]        blu;
    logic [RGB_W-1:0]  n_color;

    always_comb begin
        sum = QSUM_W'(i_quo[0]) + QSUM_W'(i_quo[1]) + QSUM_W'(i_quo[2]);
        n_int = (sum > QSUM_W'(SAT_MAX)) ? SAT_MAX : sum[INT_W-1:0];
    end

    always_comb begin
        case (r_int[7:6])
            2'b00: begin
                red = {1'b0, r_int[5:0], 1'b0};
                grn = 8'd0;
                blu = 8'd64 + {2'b00, r_int[5:0]} + {1'b0, r_int[5:0], 1'b0};
            end
            2'b01: begin
                red = {1'b1, r_int[5:0], 1'b0};
                grn = 8'd0;
                blu = 8'd255 - {r_int[5:0], 2'b00};
            end
            2'b10: begin
                red = 8'd255;
                grn = {r_int[5:0], 2'b00};
                blu = 8'd0;
            end
            default: begin
                red = 8'd255;
                grn = 8'd255;
                blu = {r_int[5:0], 2'b00};
            end
        endcase
        n_color = {red[7:3], grn[7:2], blu[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_int     <= n_int;
            r_out_int <= r_int;
            r_color   <= n_color;
        end
    end

    assign o_valid     = r_valid[1];
    assign o_intensity = r_out_int;
    assign o_color     = r_color;

endmodule
`default_nettype wire

@@ rtl/mbfps_checker.sv @@
// ---------------------------------------------------------------------------
// mbfps_checker
// Port-level checks on the shaded pixel output.
// ---------------------------------------------------------------------------
`default_nettype none
module mbfps_checker
    import mbfps_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_valid,
    input wire              i_ready,
    input wire [INT_W-1:0]  i_intensity,
    input wire [RGB_W-1:0]  i_color
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_valid && !i_ready) |-> (i_valid && $stable(i_intensity) && $stable(i_color)))
        else $error("stalled result changed");

    a_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_intensity[7:6] == 2'b11) |-> i_color[15:5] == 11'h7ff)
        else $error("top palette segment not red and green saturated");

    a_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_intensity[7]) |-> i_color[10:5] == 6'd0)
        else $error("green present below mid intensity");

endmodule

bind metaball_field_pixel_shader_top mbfps_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_shade.valid),
    .i_ready     (o_shade.ready),
    .i_intensity (o_shade.intensity),
    .i_color     (o_shade.color_rgb565)
);
`default_nettype wire
